/* hdl/tfn_pkg.sv */
`timescale 1ns / 1ps
// shared types for the triangle face normal core
// no dependencies

package tfn_pkg;

  // pipeline step control handed to the arithmetic sub-pipelines
  typedef struct packed {
    logic advance;  // whole pipeline moves one stage this cycle
    logic valid;    // a request enters the sub-pipeline
  } tfn_step_t;

endpackage

/* hdl/tfn_in_if.sv */
`timescale 1ns / 1ps
// request channel: three triangle vertices with valid/ready
// no dependencies

interface tfn_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_x;
  logic signed [COORD_WIDTH-1:0] first_y;
  logic signed [COORD_WIDTH-1:0] first_z;
  logic signed [COORD_WIDTH-1:0] second_x;
  logic signed [COORD_WIDTH-1:0] second_y;
  logic signed [COORD_WIDTH-1:0] second_z;
  logic signed [COORD_WIDTH-1:0] third_x;
  logic signed [COORD_WIDTH-1:0] third_y;
  logic signed [COORD_WIDTH-1:0] third_z;

  modport source (
    output valid, first_x, first_y, first_z, second_x, second_y, second_z,
           third_x, third_y, third_z,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
           third_x, third_y, third_z,
    output ready
  );
endinterface

/* hdl/tfn_out_if.sv */
`timescale 1ns / 1ps
// result channel: unit normal and degenerate flag with valid/ready
// no dependencies

interface tfn_out_if #(
  parameter int NORMAL_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [NORMAL_WIDTH-1:0] normal_x;
  logic signed [NORMAL_WIDTH-1:0] normal_y;
  logic signed [NORMAL_WIDTH-1:0] normal_z;
  logic                           degenerate;

  modport source (
    output valid, normal_x, normal_y, normal_z, degenerate,
    input  ready
  );
  modport sink (
    input  valid, normal_x, normal_y, normal_z, degenerate,
    output ready
  );
endinterface

/* hdl/tfn_isqrt.sv */
`timescale 1ns / 1ps
// pipelined integer square root, one root bit per stage
// depends on tfn_pkg

module tfn_isqrt
  import tfn_pkg::*;
#(
  parameter int SQ_WIDTH = 70
) (
  input  logic                    clk,
  input  logic                    rst,
  input  tfn_step_t               step,
  input  logic [SQ_WIDTH-1:0]     sq,
  output logic                    root_valid,
  output logic [SQ_WIDTH/2-1:0]   root
);
  localparam int RW  = SQ_WIDTH / 2;
  localparam int RMW = RW + 2;

  logic [RMW-1:0]      rem_r  [RW];
  logic [RW-1:0]       root_r [RW];
  logic [SQ_WIDTH-1:0] sq_r   [RW];
  logic                vld_r  [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [RMW-1:0]      rem_src;
    logic [RW-1:0]       root_src;
    logic [SQ_WIDTH-1:0] sq_src;
    logic                vld_src;
    logic [RMW+1:0]      cur;
    logic [RMW+1:0]      trial;
    logic                fits;

    if (i == 0) begin : g_first
      assign rem_src  = '0;
      assign root_src = '0;
      assign sq_src   = sq;
      assign vld_src  = step.valid;
    end else begin : g_next
      assign rem_src  = rem_r[i-1];
      assign root_src = root_r[i-1];
      assign sq_src   = sq_r[i-1];
      assign vld_src  = vld_r[i-1];
    end

    // bring down the next bit pair, try root*4+1
    assign cur   = {rem_src, sq_src[SQ_WIDTH-1-2*i -: 2]};
    assign trial = {RMW'(root_src), 2'b01};
    assign fits  = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[i] <= 1'b0;
      end else if (step.advance) begin
        vld_r[i] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (step.advance) begin
        rem_r[i]  <= fits ? RMW'(cur - trial) : RMW'(cur);
        root_r[i] <= {root_src[RW-2:0], fits};
        sq_r[i]   <= sq_src;
      end
    end
  end

  assign root_valid = vld_r[RW-1];
  assign root       = root_r[RW-1];
endmodule

/* hdl/tfn_div.sv */
`timescale 1ns / 1ps
// pipelined restoring divider for one normal component, one quotient bit per stage
// depends on tfn_pkg

module tfn_div
  import tfn_pkg::*;
#(
  parameter int MAG_WIDTH    = 34,
  parameter int DEN_WIDTH    = 35,
  parameter int NORMAL_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  tfn_step_t               step,
  input  logic [MAG_WIDTH-1:0]    mag,
  input  logic [DEN_WIDTH-1:0]    den,
  output logic                    quot_valid,
  output logic [NORMAL_WIDTH-1:0] quot
);
  localparam int RDW = DEN_WIDTH + 1;

  logic [RDW-1:0]          rem_r  [NORMAL_WIDTH];
  logic [DEN_WIDTH-1:0]    den_r  [NORMAL_WIDTH];
  logic [NORMAL_WIDTH-1:0] quot_r [NORMAL_WIDTH];
  logic                    vld_r  [NORMAL_WIDTH];

  for (genvar i = 0; i < NORMAL_WIDTH; i++) begin : g_stage
    logic [RDW-1:0]          cur;
    logic [DEN_WIDTH-1:0]    den_src;
    logic [NORMAL_WIDTH-1:0] quot_src;
    logic                    vld_src;
    logic                    fits;

    // magnitude never exceeds the length, so the first bit weighs one
    if (i == 0) begin : g_first
      assign cur      = RDW'(mag);
      assign den_src  = den;
      assign quot_src = '0;
      assign vld_src  = step.valid;
    end else begin : g_next
      assign cur      = {rem_r[i-1][RDW-2:0], 1'b0};
      assign den_src  = den_r[i-1];
      assign quot_src = quot_r[i-1];
      assign vld_src  = vld_r[i-1];
    end

    assign fits = (cur >= RDW'(den_src));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[i] <= 1'b0;
      end else if (step.advance) begin
        vld_r[i] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (step.advance) begin
        rem_r[i]  <= fits ? RDW'(cur - RDW'(den_src)) : cur;
        den_r[i]  <= den_src;
        quot_r[i] <= {quot_src[NORMAL_WIDTH-2:0], fits};
      end
    end
  end

  assign quot_valid = vld_r[NORMAL_WIDTH-1];
  assign quot       = quot_r[NORMAL_WIDTH-1];
endmodule

/* hdl/triangle_face_normal_core.sv */
`timescale 1ns / 1ps
// triangle face normal core: top level pipeline
// depends on tfn_pkg, tfn_in_if, tfn_out_if, tfn_isqrt, tfn_div

// Takes one triangle per clock while the pipeline is not held and returns
// its unit normal, one result per request, in order. Edges from the first
// vertex are crossed exactly, the squared length is summed exactly and its
// floor square root is taken, then each component magnitude is divided by
// that length into signed Q1.(NORMAL_WIDTH-1), saturating +/-1.0 to
// +/-(2^(NORMAL_WIDTH-1)-1). A zero cross product gives a zero normal with
// degenerate set. Throughput is one request per cycle while the pipeline is
// not held. A result passes through the front stages, the bit-per-stage
// square root and divider pipelines and the result register; the root
// width is L = 2*COORD_WIDTH + 3. The whole pipeline holds when the final
// result register is full and not taken, so the request side is ready
// whenever the result side is ready or empty.

module triangle_face_normal_core
  import tfn_pkg::*;
#(
  parameter int COORD_WIDTH  = 16,
  parameter int NORMAL_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  tfn_in_if.sink    tri_in,
  tfn_out_if.source nrm_out
);
  // derived widths
  localparam int EW  = COORD_WIDTH + 1;  // edge component
  localparam int PW  = 2 * EW;           // edge product
  localparam int NRW = PW + 1;           // signed cross component
  localparam int MW  = PW;               // cross component magnitude
  localparam int SQW = 2 * MW;           // one square
  localparam int SW  = SQW + 2;          // sum of three squares
  localparam int RW  = SW / 2;           // root width
  localparam logic [NORMAL_WIDTH-1:0] MAX_POS = {1'b0, {(NORMAL_WIDTH-1){1'b1}}};

  // side data carried beside the root and divider pipelines
  typedef struct packed {
    logic [MW-1:0] mag_x;
    logic [MW-1:0] mag_y;
    logic [MW-1:0] mag_z;
    logic          neg_x;
    logic          neg_y;
    logic          neg_z;
    logic          degen;
  } root_side_t;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic neg_z;
    logic degen;
  } div_side_t;

  logic advance;

  // stage 1: edge vectors
  logic signed [EW-1:0] ux, uy, uz, vx, vy, vz;
  logic                 v1;
  // stage 2: edge products, a pair per cross component
  logic signed [PW-1:0] p_nx_a, p_nx_b, p_ny_a, p_ny_b, p_nz_a, p_nz_b;
  logic                 v2;
  // stage 3: cross product
  logic signed [NRW-1:0] nx, ny, nz;
  logic                  v3;
  // stage 4: magnitudes and signs
  logic [MW-1:0] m4_x, m4_y, m4_z;
  logic          n4_x, n4_y, n4_z;
  logic          v4;
  // stage 5: squares
  logic [SQW-1:0] sq_x, sq_y, sq_z;
  logic [MW-1:0]  m5_x, m5_y, m5_z;
  logic           n5_x, n5_y, n5_z;
  logic           zero5;
  logic           v5;
  // stage 6: squared length
  logic [SW-1:0]  len_sq;
  root_side_t     side6;
  logic           v6;

  root_side_t     root_side [RW];
  div_side_t      div_side  [NORMAL_WIDTH];

  tfn_step_t         root_step, div_step;
  logic              root_valid;
  logic [RW-1:0]     root;
  logic              qx_valid, qy_valid, qz_valid;
  logic [NORMAL_WIDTH-1:0] qx, qy, qz;

  // result register
  logic                           res_valid;
  logic signed [NORMAL_WIDTH-1:0] res_x, res_y, res_z;
  logic                           res_degen;

  // a full result register that is not taken holds the whole pipeline
  assign advance      = !res_valid || nrm_out.ready;
  assign tri_in.ready = advance;

  // valid chain through the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (advance) begin
      v1 <= tri_in.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // front datapath
  always_ff @(posedge clk) begin
    if (advance) begin
      // edges from the first vertex
      ux <= EW'(tri_in.second_x) - EW'(tri_in.first_x);
      uy <= EW'(tri_in.second_y) - EW'(tri_in.first_y);
      uz <= EW'(tri_in.second_z) - EW'(tri_in.first_z);
      vx <= EW'(tri_in.third_x) - EW'(tri_in.first_x);
      vy <= EW'(tri_in.third_y) - EW'(tri_in.first_y);
      vz <= EW'(tri_in.third_z) - EW'(tri_in.first_z);

      // products for the cross terms
      p_nx_a <= PW'(uy) * PW'(vz);
      p_nx_b <= PW'(vy) * PW'(uz);
      p_ny_a <= PW'(vx) * PW'(uz);
      p_ny_b <= PW'(ux) * PW'(vz);
      p_nz_a <= PW'(ux) * PW'(vy);
      p_nz_b <= PW'(vx) * PW'(uy);

      // cross product, exact
      nx <= NRW'(p_nx_a) - NRW'(p_nx_b);
      ny <= NRW'(p_ny_a) - NRW'(p_ny_b);
      nz <= NRW'(p_nz_a) - NRW'(p_nz_b);

      // sign and magnitude
      m4_x <= MW'(nx[NRW-1] ? -nx : nx);
      m4_y <= MW'(ny[NRW-1] ? -ny : ny);
      m4_z <= MW'(nz[NRW-1] ? -nz : nz);
      n4_x <= nx[NRW-1];
      n4_y <= ny[NRW-1];
      n4_z <= nz[NRW-1];

      // squares of the magnitudes
      sq_x  <= SQW'(m4_x) * SQW'(m4_x);
      sq_y  <= SQW'(m4_y) * SQW'(m4_y);
      sq_z  <= SQW'(m4_z) * SQW'(m4_z);
      m5_x  <= m4_x;
      m5_y  <= m4_y;
      m5_z  <= m4_z;
      n5_x  <= n4_x;
      n5_y  <= n4_y;
      n5_z  <= n4_z;
      zero5 <= (m4_x == '0) && (m4_y == '0) && (m4_z == '0);

      // squared length
      len_sq      <= SW'(sq_x) + SW'(sq_y) + SW'(sq_z);
      side6.mag_x <= m5_x;
      side6.mag_y <= m5_y;
      side6.mag_z <= m5_z;
      side6.neg_x <= n5_x;
      side6.neg_y <= n5_y;
      side6.neg_z <= n5_z;
      side6.degen <= zero5;
    end
  end

  // floor square root of the squared length
  assign root_step.advance = advance;
  assign root_step.valid   = v6;

  tfn_isqrt #(
    .SQ_WIDTH (SW)
  ) u_isqrt (
    .clk        (clk),
    .rst        (rst),
    .step       (root_step),
    .sq         (len_sq),
    .root_valid (root_valid),
    .root       (root)
  );

  // side data delayed to meet the root
  for (genvar i = 0; i < RW; i++) begin : g_root_side
    always_ff @(posedge clk) begin
      if (advance) begin
        root_side[i] <= (i == 0) ? side6 : root_side[(i == 0) ? 0 : i - 1];
      end
    end
  end

  // one divider per component, all sharing the length
  assign div_step.advance = advance;
  assign div_step.valid   = root_valid;

  tfn_div #(
    .MAG_WIDTH    (MW),
    .DEN_WIDTH    (RW),
    .NORMAL_WIDTH (NORMAL_WIDTH)
  ) u_div_x (
    .clk        (clk),
    .rst        (rst),
    .step       (div_step),
    .mag        (root_side[RW-1].mag_x),
    .den        (root),
    .quot_valid (qx_valid),
    .quot       (qx)
  );

  tfn_div #(
    .MAG_WIDTH    (MW),
    .DEN_WIDTH    (RW),
    .NORMAL_WIDTH (NORMAL_WIDTH)
  ) u_div_y (
    .clk        (clk),
    .rst        (rst),
    .step       (div_step),
    .mag        (root_side[RW-1].mag_y),
    .den        (root),
    .quot_valid (qy_valid),
    .quot       (qy)
  );

  tfn_div #(
    .MAG_WIDTH    (MW),
    .DEN_WIDTH    (RW),
    .NORMAL_WIDTH (NORMAL_WIDTH)
  ) u_div_z (
    .clk        (clk),
    .rst        (rst),
    .step       (div_step),
    .mag        (root_side[RW-1].mag_z),
    .den        (root),
    .quot_valid (qz_valid),
    .quot       (qz)
  );

  // signs and degenerate flag delayed to meet the quotients
  for (genvar i = 0; i < NORMAL_WIDTH; i++) begin : g_div_side
    always_ff @(posedge clk) begin
      if (advance) begin
        if (i == 0) begin
          div_side[i].neg_x <= root_side[RW-1].neg_x;
          div_side[i].neg_y <= root_side[RW-1].neg_y;
          div_side[i].neg_z <= root_side[RW-1].neg_z;
          div_side[i].degen <= root_side[RW-1].degen;
        end else begin
          div_side[i] <= div_side[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  // saturate a quotient of one, then apply the sign; a degenerate triangle gives zero
  function automatic logic [NORMAL_WIDTH-1:0] finish_comp(
    input logic [NORMAL_WIDTH-1:0] q,
    input logic                    neg,
    input logic                    degen
  );
    logic [NORMAL_WIDTH-1:0] mag;
    mag = q[NORMAL_WIDTH-1] ? MAX_POS : q;
    if (degen) begin
      return '0;
    end
    return neg ? -mag : mag;
  endfunction

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= qx_valid && qy_valid && qz_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_x     <= finish_comp(qx, div_side[NORMAL_WIDTH-1].neg_x,
                               div_side[NORMAL_WIDTH-1].degen);
      res_y     <= finish_comp(qy, div_side[NORMAL_WIDTH-1].neg_y,
                               div_side[NORMAL_WIDTH-1].degen);
      res_z     <= finish_comp(qz, div_side[NORMAL_WIDTH-1].neg_z,
                               div_side[NORMAL_WIDTH-1].degen);
      res_degen <= div_side[NORMAL_WIDTH-1].degen;
    end
  end

  assign nrm_out.valid      = res_valid;
  assign nrm_out.normal_x   = res_x;
  assign nrm_out.normal_y   = res_y;
  assign nrm_out.normal_z   = res_z;
  assign nrm_out.degenerate = res_degen;
endmodule

/* tb/tb_triangle_face_normal_core.sv */
`timescale 1ns / 1ps
// testbench for triangle_face_normal_core: directed and random triangles
// depends on tfn_pkg, tfn_in_if, tfn_out_if and the core itself

module tb_triangle_face_normal_core;

  localparam int CW = 16;
  localparam int NW = 16;
  localparam int LATENCY = 7 + (2 * CW + 3) + NW;
  localparam int N_RANDOM = 850;

  typedef struct packed {
    logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  } triangle_t;

  typedef struct packed {
    logic signed [NW-1:0] nx, ny, nz;
    logic                 degenerate;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tfn_in_if  #(.COORD_WIDTH(CW))  tri_in ();
  tfn_out_if #(.NORMAL_WIDTH(NW)) nrm_out ();

  triangle_face_normal_core #(.COORD_WIDTH(CW), .NORMAL_WIDTH(NW)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .tri_in  (tri_in.sink),
    .nrm_out (nrm_out.source)
  );

  // clock: 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  triangle_t pending_tris[$];
  normal_t   expected_normals[$];
  int        fail_count = 0;
  bit        stim_done = 1'b0;
  bit        hold_sender = 1'b0;
  bit        in_accepted = 1'b0;
  bit        out_accepted = 1'b0;

  // floor square root of an unsigned 128-bit value, bit by bit
  function automatic logic [63:0] floor_sqrt(input logic [127:0] s);
    logic [63:0]  r;
    logic [63:0]  c;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      c = r | (64'd1 << k);
      if ({64'd0, c} * {64'd0, c} <= s) r = c;
    end
    return r;
  endfunction

  // one component: |n| * 2^(NW-1) / len, saturated, sign of n
  function automatic logic signed [NW-1:0] unit_component(input logic signed [63:0] n,
                                                          input logic [63:0] len);
    logic [127:0] mag;
    logic [127:0] quot;
    logic [NW-1:0] v;
    mag  = n < 0 ? 128'(-n) : 128'(n);
    quot = (mag << (NW - 1)) / {64'd0, len};
    if (quot > (128'd1 << (NW - 1)) - 1) v = NW'((1 << (NW - 1)) - 1);
    else v = quot[NW-1:0];
    return n < 0 ? -v : v;
  endfunction

  // expected unit normal of one triangle, exact integer arithmetic
  function automatic normal_t face_normal(input triangle_t t);
    logic signed [63:0] ux, uy, uz, vx, vy, vz, nx, ny, nz;
    logic [127:0] sq;
    logic [63:0]  len;
    normal_t      r;
    ux = 64'(t.bx) - 64'(t.ax);
    uy = 64'(t.by) - 64'(t.ay);
    uz = 64'(t.bz) - 64'(t.az);
    vx = 64'(t.cx) - 64'(t.ax);
    vy = 64'(t.cy) - 64'(t.ay);
    vz = 64'(t.cz) - 64'(t.az);
    nx = uy * vz - vy * uz;
    ny = vx * uz - ux * vz;
    nz = ux * vy - vx * uy;
    // squares of the magnitudes, taken in 128 bits
    sq = {64'd0, (nx < 0 ? -nx : nx)} * {64'd0, (nx < 0 ? -nx : nx)}
       + {64'd0, (ny < 0 ? -ny : ny)} * {64'd0, (ny < 0 ? -ny : ny)}
       + {64'd0, (nz < 0 ? -nz : nz)} * {64'd0, (nz < 0 ? -nz : nz)};
    if (sq == 0) begin
      r = '{nx: '0, ny: '0, nz: '0, degenerate: 1'b1};
    end else begin
      len = floor_sqrt(sq);
      r.nx = unit_component(nx, len);
      r.ny = unit_component(ny, len);
      r.nz = unit_component(nz, len);
      r.degenerate = 1'b0;
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1:       return CW'($signed($urandom_range(0, 64)) - 32);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic triangle_t make_tri(input int a0, a1, a2, b0, b1, b2, c0, c1, c2);
    return '{ax: CW'(a0), ay: CW'(a1), az: CW'(a2), bx: CW'(b0), by: CW'(b1),
             bz: CW'(b2), cx: CW'(c0), cy: CW'(c1), cz: CW'(c2)};
  endfunction

  // driver: next request put up at the falling edge after a random gap
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      tri_in.valid <= 1'b0;
    end else if (tri_in.valid && !in_accepted) begin
      // request still waiting: hold it
    end else begin
      if (send_gap > 0 || hold_sender || pending_tris.size() == 0) begin
        tri_in.valid <= 1'b0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end else begin
        triangle_t t;
        t = pending_tris.pop_front();
        {tri_in.first_x, tri_in.first_y, tri_in.first_z,
         tri_in.second_x, tri_in.second_y, tri_in.second_z,
         tri_in.third_x, tri_in.third_y, tri_in.third_z} <= t;
        tri_in.valid <= 1'b1;
        send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 4);
      end
    end
  end

  // record the expectation at the accepting edge
  always @(posedge clk) begin
    in_accepted <= !rst && tri_in.valid && tri_in.ready;
    if (!rst && tri_in.valid && tri_in.ready)
      expected_normals.push_back(face_normal({tri_in.first_x, tri_in.first_y,
        tri_in.first_z, tri_in.second_x, tri_in.second_y, tri_in.second_z,
        tri_in.third_x, tri_in.third_y, tri_in.third_z}));
  end

  // result side stalls, drawn per result
  int stall_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      nrm_out.ready <= 1'b0;
    end else if (stall_left > 0) begin
      nrm_out.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      nrm_out.ready <= 1'b1;
      if (out_accepted)
        stall_left <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 4);
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    out_accepted <= !rst && nrm_out.valid && nrm_out.ready;
    if (!rst && nrm_out.valid && nrm_out.ready) begin
      if (expected_normals.size() == 0) begin
        $error("unexpected result");
        fail_count++;
      end else begin
        normal_t e;
        e = expected_normals.pop_front();
        if (nrm_out.normal_x !== e.nx) begin
          $error("normal_x expected %0d got %0d", e.nx, nrm_out.normal_x);
          fail_count++;
        end
        if (nrm_out.normal_y !== e.ny) begin
          $error("normal_y expected %0d got %0d", e.ny, nrm_out.normal_y);
          fail_count++;
        end
        if (nrm_out.normal_z !== e.nz) begin
          $error("normal_z expected %0d got %0d", e.nz, nrm_out.normal_z);
          fail_count++;
        end
        if (nrm_out.degenerate !== e.degenerate) begin
          $error("degenerate expected %0b got %0b", e.degenerate, nrm_out.degenerate);
          fail_count++;
        end
      end
    end
  end

  initial begin
    tri_in.valid = 1'b0;
    {tri_in.first_x, tri_in.first_y, tri_in.first_z, tri_in.second_x,
     tri_in.second_y, tri_in.second_z, tri_in.third_x, tri_in.third_y,
     tri_in.third_z} = '0;
    nrm_out.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // directed: axis normals, coincident and collinear, extremes, skewed lengths
    pending_tris.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    pending_tris.push_back(make_tri(0, 0, 0, 0, 1, 0, 1, 0, 0));
    pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0));
    pending_tris.push_back(make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1));
    pending_tris.push_back(make_tri(5, 5, 5, 5, 5, 5, 5, 5, 5));
    pending_tris.push_back(make_tri(0, 0, 0, 1, 2, 3, 2, 4, 6));
    pending_tris.push_back(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                                    -32768, -32768, -32768));
    pending_tris.push_back(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                                    -32768, 32767, -32768));
    pending_tris.push_back(make_tri(32767, 32767, 32767, -32768, 32767, 32767,
                                    32767, 32767, -32768));
    pending_tris.push_back(make_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                                    32767, 32767, -32768));
    pending_tris.push_back(make_tri(0, 0, 0, 1, 1, 0, 0, 1, 1));
    pending_tris.push_back(make_tri(0, 0, 0, 1, 0, 0, 1, 1, 1));
    pending_tris.push_back(make_tri(0, 0, 0, 3, 0, 0, 0, 4, 1));
    pending_tris.push_back(make_tri(-1, -1, -1, -1, -1, -1, 0, 0, 0));
    pending_tris.push_back(make_tri(100, -7, 3, -2000, 9, 31000, 7, -32000, 12));

    // first pause: let everything drain before the random part
    wait (pending_tris.size() == 0);
    hold_sender = 1'b1;
    wait (expected_normals.size() == 0 && !tri_in.valid);
    repeat (LATENCY + 5) @(posedge clk);
    hold_sender = 1'b0;

    for (int i = 0; i < N_RANDOM; i++) begin
      triangle_t t;
      if ($urandom_range(0, 19) == 0) begin
        // collinear: third vertex on the line of the first edge
        t.ax = rand_coord(); t.ay = rand_coord(); t.az = rand_coord();
        t.bx = t.ax + CW'($urandom_range(0, 20)); t.by = t.ay + CW'($urandom_range(0, 20));
        t.bz = t.az;
        t.cx = CW'(t.ax + 2 * (t.bx - t.ax)); t.cy = CW'(t.ay + 2 * (t.by - t.ay));
        t.cz = t.az;
      end else begin
        t = '{ax: rand_coord(), ay: rand_coord(), az: rand_coord(),
              bx: rand_coord(), by: rand_coord(), bz: rand_coord(),
              cx: rand_coord(), cy: rand_coord(), cz: rand_coord()};
      end
      pending_tris.push_back(t);
    end

    wait (pending_tris.size() == 0 && !tri_in.valid);
    wait (expected_normals.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    stim_done = 1'b1;
  end

  // end of run: verdict once the stimulus is done (the watchdog can also fail the run)
  initial begin
    wait (stim_done);
    if (fail_count == 0 && expected_normals.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
